// ----- design/ppre_pkg.sv -----
// Package for the packed pixel run-length expander.
// Widths, register indexes, reset values, state codes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package ppre_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned CNT_W   = 15;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CFG_W   = 8;

  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned STEP_W    = 3;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [IDX_W-1:0] CFG_RUN_MODE    = 3'd0;
  localparam logic [IDX_W-1:0] CFG_RED_SHIFT   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_GREEN_SHIFT = 3'd2;
  localparam logic [IDX_W-1:0] CFG_BLUE_SHIFT  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_RED_MAX     = 3'd4;
  localparam logic [IDX_W-1:0] CFG_GREEN_MAX   = 3'd5;
  localparam logic [IDX_W-1:0] CFG_BLUE_MAX    = 3'd6;

  localparam logic               RST_RUN_MODE    = 1'b1;
  localparam logic [SHIFT_W-1:0] RST_RED_SHIFT   = 4'd11;
  localparam logic [SHIFT_W-1:0] RST_GREEN_SHIFT = 4'd5;
  localparam logic [SHIFT_W-1:0] RST_BLUE_SHIFT  = 4'd0;
  localparam logic [CHAN_W-1:0]  RST_RED_MAX     = 8'd31;
  localparam logic [CHAN_W-1:0]  RST_GREEN_MAX   = 8'd63;
  localparam logic [CHAN_W-1:0]  RST_BLUE_MAX    = 8'd31;

  localparam logic [CNT_W-1:0] LITERAL_COUNT = 15'd1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  typedef struct packed {
    logic start;
    logic step;
    logic ld_hdr;
    logic clr_hdr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic run_mode;
    logic hdr_seen;
    logic out_full;
  } sts_t;

endpackage

// ----- design/ppre_div.sv -----
// One channel: field extraction, scale by 255 and restoring divide by max.
// Depends on ppre_pkg.
`timescale 1ns / 1ps
module ppre_div (
  input  logic                          clk_i,
  input  logic                          start_i,
  input  logic                          step_i,
  input  logic [ppre_pkg::WORD_W-1:0]   word_i,
  input  logic [ppre_pkg::SHIFT_W-1:0]  shift_i,
  input  logic [ppre_pkg::CHAN_W-1:0]   max_i,
  output logic [ppre_pkg::CHAN_W-1:0]   quot_o
);

  logic [ppre_pkg::WORD_W-1:0] shifted;
  logic [ppre_pkg::CHAN_W-1:0] field;
  logic [ppre_pkg::WORD_W-1:0] prod;
  logic [ppre_pkg::CHAN_W:0]   trial;
  logic [ppre_pkg::CHAN_W:0]   diff;
  logic                        ge;

  logic [ppre_pkg::CHAN_W-1:0] rem_q, rem_d;
  logic [ppre_pkg::CHAN_W-1:0] quo_q, quo_d;
  logic                        zero_q, zero_d;

  assign shifted = word_i >> shift_i;
  assign field   = shifted[ppre_pkg::CHAN_W-1:0] & max_i;
  // field * 255; high byte is below max, so the quotient fits 8 bits
  assign prod    = {field, 8'd0} - {8'd0, field};

  assign trial = {rem_q, quo_q[ppre_pkg::CHAN_W-1]};
  assign diff  = trial - {1'b0, max_i};
  assign ge    = (trial >= {1'b0, max_i});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    zero_d = zero_q;
    if (start_i) begin
      rem_d  = prod[ppre_pkg::WORD_W-1:ppre_pkg::CHAN_W];
      quo_d  = prod[ppre_pkg::CHAN_W-1:0];
      zero_d = (max_i == '0);
    end else if (step_i) begin
      rem_d = ge ? diff[ppre_pkg::CHAN_W-1:0] : trial[ppre_pkg::CHAN_W-1:0];
      quo_d = {quo_q[ppre_pkg::CHAN_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    zero_q <= zero_d;
  end

  assign quot_o = zero_q ? '0 : quo_q;

endmodule

// ----- design/ppre_dp.sv -----
// Datapath: config registers, header state, three channel dividers and
// the output register. Depends on ppre_pkg and ppre_div.
`timescale 1ns / 1ps
module ppre_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ppre_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [ppre_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic [ppre_pkg::WORD_W-1:0]         word_i,
  input  logic                                last_i,
  input  ppre_pkg::cmd_t                      cmd_i,
  output ppre_pkg::sts_t                      sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [ppre_pkg::OUT_TDATA_W-1:0]    out_data_o,
  output logic                                out_last_o
);

  logic                         run_mode_q;
  logic [ppre_pkg::SHIFT_W-1:0] red_shift_q, green_shift_q, blue_shift_q;
  logic [ppre_pkg::CHAN_W-1:0]  red_max_q, green_max_q, blue_max_q;

  logic                         hdr_seen_q, hdr_seen_d;
  logic [ppre_pkg::CNT_W-1:0]   pend_q, pend_d;
  logic [ppre_pkg::CNT_W-1:0]   count_q;
  logic                         last_q;

  logic [ppre_pkg::CHAN_W-1:0]  red, green, blue;

  logic                         out_valid_q, out_valid_d;
  logic [ppre_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic                         out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q    <= ppre_pkg::RST_RUN_MODE;
      red_shift_q   <= ppre_pkg::RST_RED_SHIFT;
      green_shift_q <= ppre_pkg::RST_GREEN_SHIFT;
      blue_shift_q  <= ppre_pkg::RST_BLUE_SHIFT;
      red_max_q     <= ppre_pkg::RST_RED_MAX;
      green_max_q   <= ppre_pkg::RST_GREEN_MAX;
      blue_max_q    <= ppre_pkg::RST_BLUE_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppre_pkg::CFG_RUN_MODE:    run_mode_q    <= cfg_data_i[0];
        ppre_pkg::CFG_RED_SHIFT:   red_shift_q   <= cfg_data_i[ppre_pkg::SHIFT_W-1:0];
        ppre_pkg::CFG_GREEN_SHIFT: green_shift_q <= cfg_data_i[ppre_pkg::SHIFT_W-1:0];
        ppre_pkg::CFG_BLUE_SHIFT:  blue_shift_q  <= cfg_data_i[ppre_pkg::SHIFT_W-1:0];
        ppre_pkg::CFG_RED_MAX:     red_max_q     <= cfg_data_i;
        ppre_pkg::CFG_GREEN_MAX:   green_max_q   <= cfg_data_i;
        ppre_pkg::CFG_BLUE_MAX:    blue_max_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    hdr_seen_d = hdr_seen_q;
    pend_d     = pend_q;
    if (cmd_i.ld_hdr) begin
      hdr_seen_d = 1'b1;
      pend_d     = word_i[ppre_pkg::CNT_W-1:0];
    end else if (cmd_i.clr_hdr) begin
      hdr_seen_d = 1'b0;
      pend_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_seen_q <= 1'b0;
      pend_q     <= '0;
    end else begin
      hdr_seen_q <= hdr_seen_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      count_q <= (run_mode_q && hdr_seen_q) ? pend_q : ppre_pkg::LITERAL_COUNT;
      last_q  <= last_i;
    end
  end

  ppre_div u_div_red (
    .clk_i  (clk_i),
    .start_i(cmd_i.start),
    .step_i (cmd_i.step),
    .word_i (word_i),
    .shift_i(red_shift_q),
    .max_i  (red_max_q),
    .quot_o (red)
  );

  ppre_div u_div_green (
    .clk_i  (clk_i),
    .start_i(cmd_i.start),
    .step_i (cmd_i.step),
    .word_i (word_i),
    .shift_i(green_shift_q),
    .max_i  (green_max_q),
    .quot_o (green)
  );

  ppre_div u_div_blue (
    .clk_i  (clk_i),
    .start_i(cmd_i.start),
    .step_i (cmd_i.step),
    .word_i (word_i),
    .shift_i(blue_shift_q),
    .max_i  (blue_max_q),
    .quot_o (blue)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {1'b0, count_q, blue, green, red};
      out_last_q <= last_q;
    end
  end

  assign sts_o.run_mode = run_mode_q;
  assign sts_o.hdr_seen = hdr_seen_q;
  assign sts_o.out_full = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- design/ppre_ctrl.sv -----
// Controller: word decode, divide step sequencing and output hand-off.
// Depends on ppre_pkg.
`timescale 1ns / 1ps
module ppre_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           hdr_flag_i,
  input  logic           last_i,
  input  logic           out_ready_i,
  input  ppre_pkg::sts_t sts_i,
  output ppre_pkg::cmd_t cmd_o
);

  ppre_pkg::state_e            state_q, state_d;
  logic [ppre_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                        accept;

  assign in_ready_o = (state_q == ppre_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ppre_pkg::S_IDLE: begin
        if (accept) begin
          if (!sts_i.run_mode || sts_i.hdr_seen) begin
            cmd_o.start   = 1'b1;
            cmd_o.clr_hdr = 1'b1;
          end else if (hdr_flag_i) begin
            // header: no pixel; a final header clears the run state
            cmd_o.ld_hdr  = !last_i;
            cmd_o.clr_hdr = last_i;
          end else begin
            cmd_o.start = 1'b1;
          end
          if (cmd_o.start) begin
            state_d = ppre_pkg::S_DIV;
            cnt_d   = '0;
          end
        end
      end
      ppre_pkg::S_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == ppre_pkg::STEP_W'(ppre_pkg::DIV_STEPS - 1)) begin
          state_d = ppre_pkg::S_LOAD;
        end
      end
      ppre_pkg::S_LOAD: begin
        if (!sts_i.out_full || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ppre_pkg::S_IDLE;
        end
      end
      default: state_d = ppre_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppre_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- design/packed_pixel_rle_expander.sv -----
// Packed pixel run-length expander, top level. Depends on ppre_pkg, ppre_ctrl, ppre_dp.
// Steps: a taken pixel word is loaded into the dividers, runs 8 restoring divide
// steps, then waits in S_LOAD until the output register is free. The input stays
// not ready until then; a header word is taken without starting the dividers.
// The output register lets the next word enter while a result waits.
// Reset (async, active low) restores register defaults and clears run state.
`timescale 1ns / 1ps
module packed_pixel_rle_expander (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ppre_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [ppre_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ppre_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [15:0] image_word
  input  logic                                s_axis_tlast,  // final_word
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [38:24] repeat_count, [39] zero
  output logic [ppre_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast   // image_end
);

  ppre_pkg::cmd_t cmd;
  ppre_pkg::sts_t sts;

  ppre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .hdr_flag_i (s_axis_tdata[ppre_pkg::WORD_W-1]),
    .last_i     (s_axis_tlast),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppre_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .word_i     (s_axis_tdata[ppre_pkg::WORD_W-1:0]),
    .last_i     (s_axis_tlast),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule
